FILE: design/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg: shared types and constants for the Cartesian to spherical converter
// Word formats, arithmetic widths and the CORDIC arc tangent table.
// ----------------------------------------------------------------------------
package c2s_pkg;

  localparam int COORD_BITS       = 16;
  localparam int DEF_CORDIC_STEPS = 16;

  // Coordinates enter the CORDIC scaled by 2^PRE_SH.
  localparam int PRE_SH     = COORD_BITS - 2;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int RAD_ROOT_W = COORD_BITS;
  localparam int RHO_ROOT_W = 2 * COORD_BITS - 2;
  localparam int CORD_W     = 2 * COORD_BITS;

  // Angles run in units of pi/2^31 and leave in units of pi/2^15.
  localparam int ANG_W   = 34;
  localparam int ANG_SH  = 16;
  localparam int TAB_LEN = 32;

  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  localparam int AZ_W     = 17;
  localparam int EL_W     = 16;
  localparam int RADIUS_W = 16;
  localparam int AZ_LIM   = 32768;
  localparam int EL_LIM   = 16384;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
    logic signed [COORD_BITS-1:0] z_in;
  } pt_in_t;

  typedef struct packed {
    logic signed [AZ_W-1:0] azimuth;
    logic signed [EL_W-1:0] elevation;
    logic [RADIUS_W-1:0]    radius;
  } res_t;

endpackage

FILE: design/c2s_delay.sv
// ----------------------------------------------------------------------------
// c2s_delay: fixed-length register line
// Carries a side word alongside the cell chains so that it meets its item.
// ----------------------------------------------------------------------------
module c2s_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= d_i;
    for (int k = 1; k < DEPTH; k++) begin
      pipe_q[k] <= pipe_q[k-1];
    end
  end

  assign q_o = pipe_q[DEPTH-1];

endmodule

FILE: design/c2s_sqrt_cell.sv
// ----------------------------------------------------------------------------
// c2s_sqrt_cell: one digit of a restoring integer square root
// Takes the next two radicand bits and settles one root bit per cycle.
// ----------------------------------------------------------------------------
module c2s_sqrt_cell #(
  parameter int ROOT_W = 16,
  parameter int RAD_W  = 32
) (
  input  logic              clk_i,
  input  logic [ROOT_W:0]   rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W:0]   rem_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [RAD_W-1:0]  rad_o
);

  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] diff;
  logic              fits;
  logic [ROOT_W:0]   rem_d, rem_q;
  logic [ROOT_W-1:0] root_d, root_q;
  logic [RAD_W-1:0]  rad_d, rad_q;

  always_comb begin
    rem_sh = {rem_i, rad_i[RAD_W-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    diff   = rem_sh - trial;
    fits   = rem_sh >= trial;
    rem_d  = fits ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
    root_d = {root_i[ROOT_W-2:0], fits};
    rad_d  = {rad_i[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    rad_q  <= rad_d;
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;

endmodule

FILE: design/c2s_cordic_cell.sv
// ----------------------------------------------------------------------------
// c2s_cordic_cell: one vectoring micro-rotation
// Turns the vector toward the x axis by atan(2^-STEP) and books the angle.
// ----------------------------------------------------------------------------
module c2s_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                                clk_i,
  input  logic signed [c2s_pkg::CORD_W-1:0]  x_i,
  input  logic signed [c2s_pkg::CORD_W-1:0]  y_i,
  input  logic signed [c2s_pkg::ANG_W-1:0]   ang_i,
  output logic signed [c2s_pkg::CORD_W-1:0]  x_o,
  output logic signed [c2s_pkg::CORD_W-1:0]  y_o,
  output logic signed [c2s_pkg::ANG_W-1:0]   ang_o
);

  import c2s_pkg::*;

  localparam logic signed [ANG_W-1:0] STEP_ANG = ANG_W'(ATAN_TAB[STEP]);

  logic signed [CORD_W-1:0] dx, dy;
  logic signed [CORD_W-1:0] x_d, x_q, y_d, y_q;
  logic signed [ANG_W-1:0]  ang_d, ang_q;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (!y_i[CORD_W-1]) begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      ang_d = ang_i + STEP_ANG;
    end else begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      ang_d = ang_i - STEP_ANG;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    ang_q <= ang_d;
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign ang_o = ang_q;

endmodule

FILE: design/cartesian_to_spherical.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical: pipelined Cartesian to spherical converter
// Azimuth, elevation and rounded length of a signed point, from square root
// and CORDIC cell chains.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Word
// point     in         start high, busy low      pt_i  (x_in, y_in, z_in)
// result    out        done_o strobe, one cycle  res_o (azimuth, elevation, radius)
//
// A new point is taken in every cycle; busy stays low.
// Latency is set by the planar radius root chain, then the elevation CORDIC chain.
// Reset clears the valid pipeline only; no clearing pass is needed.
// Results cannot be held off by the receiver, so nothing ever stalls.
// ----------------------------------------------------------------------------
module cartesian_to_spherical #(
  parameter int CORDIC_STEPS = c2s_pkg::DEF_CORDIC_STEPS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  c2s_pkg::pt_in_t pt_i,
  output logic            done_o,
  output c2s_pkg::res_t   res_o
);

  import c2s_pkg::*;

  localparam int LAST  = 2 + RHO_ROOT_W + CORDIC_STEPS;
  localparam int RND_W = ANG_W - ANG_SH;

  localparam logic signed [ANG_W-1:0] ANG_RND = ANG_W'(2 ** (ANG_SH - 1));
  localparam logic signed [ANG_W-1:0] ANG_QTR = ANG_W'(QUARTER_TURN);
  localparam logic signed [RND_W-1:0] AZ_HI   = RND_W'(AZ_LIM);
  localparam logic signed [RND_W-1:0] EL_HI   = RND_W'(EL_LIM);

  typedef struct packed {
    logic                   az_fix;
    logic                   el_fix;
    logic signed [AZ_W-1:0] az_val;
    logic signed [EL_W-1:0] el_val;
  } spec_t;

  function automatic logic signed [RND_W-1:0] to_units(
    input logic signed [ANG_W-1:0] ang,
    input logic signed [RND_W-1:0] lim
  );
    logic signed [ANG_W-1:0] sum;
    logic signed [RND_W-1:0] rnd;
    sum = ang + ANG_RND;
    rnd = sum[ANG_W-1:ANG_SH];
    if (rnd > lim) begin
      rnd = lim;
    end else if (rnd < -lim) begin
      rnd = -lim;
    end
    return rnd;
  endfunction

  logic [LAST:0] vld_q;

  // Stage one: squares and special-case results.
  pt_in_t                 in1_q;
  logic signed [SQ_W-1:0] x_ext, y_ext, z_ext;
  logic [SQ_W-1:0]        sq_x_d, sq_y_d, sq_z_d, sq_x_q, sq_y_q, sq_z_q;
  logic                   x_zero, y_zero, z_zero;
  spec_t                  spec_d, spec1_q, spec_end;

  // Stage two: sums and the quadrant pre-rotation.
  logic [SQ_W-1:0]          pl_d, s_d, pl_q, s_q;
  logic signed [CORD_W-1:0] cx, cy, cx_d, cy_d, cx_q, cy_q;
  logic signed [ANG_W-1:0]  a0_d, a0_q;

  logic [RAD_ROOT_W:0]   rr_rem  [RAD_ROOT_W+1];
  logic [RAD_ROOT_W-1:0] rr_root [RAD_ROOT_W+1];
  logic [SQ_W-1:0]       rr_rad  [RAD_ROOT_W+1];

  logic [RHO_ROOT_W:0]   ho_rem  [RHO_ROOT_W+1];
  logic [RHO_ROOT_W-1:0] ho_root [RHO_ROOT_W+1];
  logic [SQ_W-1:0]       ho_rad  [RHO_ROOT_W+1];

  logic signed [CORD_W-1:0] c1_x [CORDIC_STEPS+1];
  logic signed [CORD_W-1:0] c1_y [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0]  c1_a [CORDIC_STEPS+1];
  logic signed [CORD_W-1:0] c2_x [CORDIC_STEPS+1];
  logic signed [CORD_W-1:0] c2_y [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0]  c2_a [CORDIC_STEPS+1];

  logic signed [COORD_BITS-1:0] z_dly;
  logic                         round_up;
  logic [RAD_ROOT_W:0]          rad_sum;
  logic [RADIUS_W-1:0]          rad_rnd, rad_end;
  logic signed [ANG_W-1:0]      az_ang;
  res_t                         res_d, res_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAST-1:0], start};
    end
  end

  always_comb begin
    x_ext  = SQ_W'(pt_i.x_in);
    y_ext  = SQ_W'(pt_i.y_in);
    z_ext  = SQ_W'(pt_i.z_in);
    sq_x_d = x_ext * x_ext;
    sq_y_d = y_ext * y_ext;
    sq_z_d = z_ext * z_ext;

    x_zero = pt_i.x_in == '0;
    y_zero = pt_i.y_in == '0;
    z_zero = pt_i.z_in == '0;

    spec_d.az_fix = x_zero | y_zero;
    if (y_zero) begin
      spec_d.az_val = pt_i.x_in[COORD_BITS-1] ? AZ_W'(AZ_LIM) : '0;
    end else begin
      spec_d.az_val = pt_i.y_in[COORD_BITS-1] ? -AZ_W'(EL_LIM) : AZ_W'(EL_LIM);
    end
    spec_d.el_fix = z_zero | (x_zero & y_zero);
    if (z_zero) begin
      spec_d.el_val = '0;
    end else begin
      spec_d.el_val = pt_i.z_in[COORD_BITS-1] ? -EL_W'(EL_LIM) : EL_W'(EL_LIM);
    end
  end

  always_ff @(posedge clk_i) begin
    in1_q   <= pt_i;
    sq_x_q  <= sq_x_d;
    sq_y_q  <= sq_y_d;
    sq_z_q  <= sq_z_d;
    spec1_q <= spec_d;
  end

  always_comb begin
    pl_d = sq_x_q + sq_y_q;
    s_d  = sq_x_q + sq_y_q + sq_z_q;
    cx   = CORD_W'(in1_q.x_in) <<< PRE_SH;
    cy   = CORD_W'(in1_q.y_in) <<< PRE_SH;
    if (!in1_q.x_in[COORD_BITS-1]) begin
      cx_d = cx;
      cy_d = cy;
      a0_d = '0;
    end else if (!in1_q.y_in[COORD_BITS-1]) begin
      cx_d = cy;
      cy_d = -cx;
      a0_d = ANG_QTR;
    end else begin
      cx_d = -cy;
      cy_d = cx;
      a0_d = -ANG_QTR;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q <= pl_d;
    s_q  <= s_d;
    cx_q <= cx_d;
    cy_q <= cy_d;
    a0_q <= a0_d;
  end

  assign rr_rem[0]  = '0;
  assign rr_root[0] = '0;
  assign rr_rad[0]  = s_q;

  for (genvar j = 0; j < RAD_ROOT_W; j++) begin : g_rad
    c2s_sqrt_cell #(
      .ROOT_W (RAD_ROOT_W),
      .RAD_W  (SQ_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rem_i  (rr_rem[j]),
      .root_i (rr_root[j]),
      .rad_i  (rr_rad[j]),
      .rem_o  (rr_rem[j+1]),
      .root_o (rr_root[j+1]),
      .rad_o  (rr_rad[j+1])
    );
  end

  assign ho_rem[0]  = '0;
  assign ho_root[0] = '0;
  assign ho_rad[0]  = pl_q;

  for (genvar j = 0; j < RHO_ROOT_W; j++) begin : g_rho
    c2s_sqrt_cell #(
      .ROOT_W (RHO_ROOT_W),
      .RAD_W  (SQ_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rem_i  (ho_rem[j]),
      .root_i (ho_root[j]),
      .rad_i  (ho_rad[j]),
      .rem_o  (ho_rem[j+1]),
      .root_o (ho_root[j+1]),
      .rad_o  (ho_rad[j+1])
    );
  end

  assign c1_x[0] = cx_q;
  assign c1_y[0] = cy_q;
  assign c1_a[0] = a0_q;

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_az
    c2s_cordic_cell #(
      .STEP (j)
    ) u_cell (
      .clk_i (clk_i),
      .x_i   (c1_x[j]),
      .y_i   (c1_y[j]),
      .ang_i (c1_a[j]),
      .x_o   (c1_x[j+1]),
      .y_o   (c1_y[j+1]),
      .ang_o (c1_a[j+1])
    );
  end

  c2s_delay #(
    .WIDTH (COORD_BITS),
    .DEPTH (1 + RHO_ROOT_W)
  ) u_z_dly (
    .clk_i (clk_i),
    .d_i   (in1_q.z_in),
    .q_o   (z_dly)
  );

  assign c2_x[0] = CORD_W'(ho_root[RHO_ROOT_W]);
  assign c2_y[0] = CORD_W'(z_dly) <<< PRE_SH;
  assign c2_a[0] = '0;

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_el
    c2s_cordic_cell #(
      .STEP (j)
    ) u_cell (
      .clk_i (clk_i),
      .x_i   (c2_x[j]),
      .y_i   (c2_y[j]),
      .ang_i (c2_a[j]),
      .x_o   (c2_x[j+1]),
      .y_o   (c2_y[j+1]),
      .ang_o (c2_a[j+1])
    );
  end

  always_comb begin
    round_up = rr_rem[RAD_ROOT_W] > {1'b0, rr_root[RAD_ROOT_W]};
    rad_sum  = {1'b0, rr_root[RAD_ROOT_W]} + (RAD_ROOT_W + 1)'(round_up);
    rad_rnd  = rad_sum[RAD_ROOT_W] ? '1 : RADIUS_W'(rad_sum[RAD_ROOT_W-1:0]);
  end

  c2s_delay #(
    .WIDTH (RADIUS_W),
    .DEPTH (RHO_ROOT_W + CORDIC_STEPS - RAD_ROOT_W)
  ) u_rad_dly (
    .clk_i (clk_i),
    .d_i   (rad_rnd),
    .q_o   (rad_end)
  );

  c2s_delay #(
    .WIDTH (ANG_W),
    .DEPTH (RHO_ROOT_W)
  ) u_az_dly (
    .clk_i (clk_i),
    .d_i   (c1_a[CORDIC_STEPS]),
    .q_o   (az_ang)
  );

  c2s_delay #(
    .WIDTH ($bits(spec_t)),
    .DEPTH (LAST - 1)
  ) u_spec_dly (
    .clk_i (clk_i),
    .d_i   (spec1_q),
    .q_o   (spec_end)
  );

  always_comb begin
    res_d.azimuth   = spec_end.az_fix ? spec_end.az_val
                                      : AZ_W'(to_units(az_ang, AZ_HI));
    res_d.elevation = spec_end.el_fix ? spec_end.el_val
                                      : EL_W'(to_units(c2_a[CORDIC_STEPS], EL_HI));
    res_d.radius    = rad_end;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = vld_q[LAST];
  assign res_o  = res_q;

  a_fixed_latency : assert property (
    @(posedge clk_i) disable iff (!rst_ni) start |-> ##(LAST + 1) done_o
  ) else $error("Accepted point did not produce a result word on time.");

  a_equator : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start && pt_i.z_in == '0) |-> ##(LAST + 1) (res_o.elevation == '0)
  ) else $error("Point in the equator plane gave a nonzero elevation.");

  a_zero_vector : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.radius == '0) |-> (res_o.azimuth == '0 && res_o.elevation == '0)
  ) else $error("Zero-length result word carries nonzero angles.");

  a_angle_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.elevation <= EL_W'(EL_LIM) && res_o.elevation >= -EL_W'(EL_LIM)
                && res_o.azimuth <= AZ_W'(AZ_LIM) && res_o.azimuth >= -AZ_W'(AZ_LIM))
  ) else $error("Result angle outside its range.");

endmodule

FILE: tb/sv/cartesian_to_spherical_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cartesian_to_spherical_tb: self-checking bench for the spherical converter
// Points are driven from a queue with random gaps and pauses until the
// pipeline has drained. Each accepted point is converted by a behavioral
// model of the square root and CORDIC arithmetic. Every result word is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_tb;
  import c2s_pkg::*;

  localparam int CORDIC_STEPS = DEF_CORDIC_STEPS;
  localparam int LATENCY      = 2 * COORD_BITS + 1 + CORDIC_STEPS;
  localparam int N_RANDOM     = 1080;

  typedef enum int {SPAN_FULL, SPAN_SMALL, SPAN_EDGE} span_e;

  typedef struct {
    pt_in_t      pt;
    int unsigned hold;
    bit          drain;
  } point_job_t;

  logic   clk_i  = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start  = 1'b0;
  pt_in_t pt_i   = '0;
  logic   busy;
  logic   done_o;
  res_t   res_o;

  point_job_t  point_q[$];
  res_t        sph_expected_q[$];
  int unsigned mismatches = 0;
  logic        word_taken = 1'b0;
  bit          hold_loaded = 1'b0;
  int unsigned hold_left = 0;

  cartesian_to_spherical #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .pt_i  (pt_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint root_floor(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sh4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint cordic_angle(longint vx, longint vy, longint acc);
    longint dx;
    longint dy;
    for (int i = 0; i < CORDIC_STEPS && i < TAB_LEN; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx  = vx + dx;
        vy  = vy - dy;
        acc = acc + longint'(ATAN_TAB[i]);
      end else begin
        vx  = vx - dx;
        vy  = vy + dy;
        acc = acc - longint'(ATAN_TAB[i]);
      end
    end
    return acc;
  endfunction

  function automatic longint angle_units(longint acc, longint lim);
    longint a;
    a = (acc + 32768) >>> ANG_SH;
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a;
  endfunction

  function automatic res_t predict_spherical(pt_in_t p);
    longint x, y, z, pl, s, r, az, el, cx, cy, a0, t, rho;
    res_t   q;
    x  = longint'(p.x_in);
    y  = longint'(p.y_in);
    z  = longint'(p.z_in);
    pl = x * x + y * y;
    s  = pl + z * z;
    r  = root_floor(s);
    if (s - r * r > r) r = r + 1;
    if (r > 65535) r = 65535;
    if (s == 0) begin
      az = 0;
      el = 0;
      r  = 0;
    end else if (pl == 0) begin
      az = 0;
      el = (z > 0) ? EL_LIM : -EL_LIM;
    end else begin
      if (y == 0) begin
        az = (x > 0) ? 0 : AZ_LIM;
      end else if (x == 0) begin
        az = (y > 0) ? EL_LIM : -EL_LIM;
      end else begin
        cx = x <<< PRE_SH;
        cy = y <<< PRE_SH;
        a0 = 0;
        if (cx < 0) begin
          t = cx;
          if (cy >= 0) begin
            cx = cy;
            cy = -t;
            a0 = longint'(QUARTER_TURN);
          end else begin
            cx = -cy;
            cy = t;
            a0 = -longint'(QUARTER_TURN);
          end
        end
        az = angle_units(cordic_angle(cx, cy, a0), AZ_LIM);
      end
      if (z == 0) begin
        el = 0;
      end else begin
        rho = root_floor(pl << 28);
        el  = angle_units(cordic_angle(rho, z <<< PRE_SH, 0), EL_LIM);
      end
    end
    q.azimuth   = az[AZ_W-1:0];
    q.elevation = el[EL_W-1:0];
    q.radius    = r[RADIUS_W-1:0];
    return q;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord(span_e span);
    logic signed [COORD_BITS-1:0] c;
    case (span)
      SPAN_SMALL: c = COORD_BITS'($signed($urandom_range(0, 16)) - 8);
      SPAN_EDGE: begin
        case ($urandom_range(0, 5))
          0: c = -16'sd32768;
          1: c = -16'sd32767;
          2: c = -16'sd1;
          3: c = 16'sd0;
          4: c = 16'sd1;
          default: c = 16'sd32767;
        endcase
      end
      default: c = COORD_BITS'($urandom());
    endcase
    return c;
  endfunction

  // Driver: a word is held until taken, then the next one follows its gap.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !word_taken) begin
      start <= 1'b1;
    end else if (point_q.size() == 0) begin
      start <= 1'b0;
    end else begin
      if (!hold_loaded) begin
        hold_left   = point_q[0].hold;
        hold_loaded = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        start <= 1'b0;
      end else if (point_q[0].drain && sph_expected_q.size() != 0) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        pt_i  <= point_q[0].pt;
        void'(point_q.pop_front());
        hold_loaded = 1'b0;
      end
    end
  end

  // Monitor: predicts each accepted point and checks each result word.
  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= start && !busy;
      if (start && !busy) sph_expected_q.push_back(predict_spherical(pt_i));
      if (done_o) begin
        if (sph_expected_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, res_o);
          mismatches++;
        end else begin
          want = sph_expected_q.pop_front();
          if (res_o.azimuth !== want.azimuth) begin
            $display("%0t: azimuth expected %0d actual %0d", $time, want.azimuth,
                     res_o.azimuth);
            mismatches++;
          end
          if (res_o.elevation !== want.elevation) begin
            $display("%0t: elevation expected %0d actual %0d", $time, want.elevation,
                     res_o.elevation);
            mismatches++;
          end
          if (res_o.radius !== want.radius) begin
            $display("%0t: radius expected %0d actual %0d", $time, want.radius,
                     res_o.radius);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[cartesian_to_spherical] ERROR");
    $finish;
  end

  initial begin
    point_job_t job;
    int         r;
    bit         steady;
    int         directed[][3];

    directed = '{
      '{0, 0, 0}, '{5, 0, 0}, '{-5, 0, 0}, '{0, 7, 0}, '{0, -7, 0},
      '{0, 0, 9}, '{0, 0, -9}, '{32767, 0, 0}, '{-32768, 0, 0},
      '{0, 32767, 0}, '{0, -32768, 0}, '{0, 0, 32767}, '{0, 0, -32768},
      '{-32768, -32768, -32768}, '{32767, 32767, 32767},
      '{-32768, 32767, -32768}, '{32767, -32768, 32767}, '{-1, -1, -1},
      '{1, 1, 1}, '{-1, 1, 0}, '{1, -1, 0}, '{3, 4, 0}, '{-32768, -1, 1},
      '{12000, -5000, 0}
    };
    foreach (directed[i]) begin
      job.pt.x_in = COORD_BITS'(directed[i][0]);
      job.pt.y_in = COORD_BITS'(directed[i][1]);
      job.pt.z_in = COORD_BITS'(directed[i][2]);
      job.hold    = 0;
      job.drain   = 1'b0;
      point_q.push_back(job);
    end

    steady = 1'b0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 90 == 0) steady = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 9))
        4: begin
          job.pt.x_in = rand_coord(SPAN_SMALL);
          job.pt.y_in = rand_coord(SPAN_SMALL);
          job.pt.z_in = rand_coord(SPAN_SMALL);
        end
        5: begin
          job.pt = '0;
          case ($urandom_range(0, 2))
            0: job.pt.x_in = rand_coord(SPAN_FULL);
            1: job.pt.y_in = rand_coord(SPAN_FULL);
            default: job.pt.z_in = rand_coord(SPAN_FULL);
          endcase
        end
        6: begin
          job.pt.x_in = rand_coord(SPAN_FULL);
          job.pt.y_in = rand_coord(SPAN_FULL);
          job.pt.z_in = '0;
        end
        7: begin
          job.pt.x_in = rand_coord(SPAN_SMALL);
          job.pt.y_in = rand_coord(SPAN_SMALL);
          job.pt.z_in = rand_coord(SPAN_FULL);
        end
        8: begin
          job.pt.x_in = rand_coord(SPAN_EDGE);
          job.pt.y_in = rand_coord(SPAN_EDGE);
          job.pt.z_in = rand_coord(SPAN_EDGE);
        end
        9: begin
          job.pt.x_in = rand_coord(SPAN_FULL);
          job.pt.y_in = rand_coord(SPAN_SMALL);
          job.pt.z_in = rand_coord(SPAN_FULL);
        end
        default: begin
          job.pt.x_in = rand_coord(SPAN_FULL);
          job.pt.y_in = rand_coord(SPAN_FULL);
          job.pt.z_in = rand_coord(SPAN_FULL);
        end
      endcase
      r = $urandom_range(0, 99);
      if (steady || r < 60) job.hold = 0;
      else if (r < 93) job.hold = $urandom_range(1, 3);
      else job.hold = $urandom_range(10, 60);
      job.drain = (n % 300 == 0) || ($urandom_range(0, 199) == 0);
      point_q.push_back(job);
    end

    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (point_q.size() != 0 || start) @(negedge clk_i);
    while (sph_expected_q.size() != 0) @(negedge clk_i);
    repeat (2 * LATENCY) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("[cartesian_to_spherical] OK");
    end else begin
      $display("[cartesian_to_spherical] ERROR");
    end
    $finish;
  end

endmodule
